FILE: design/flpte_pkg.sv
// ----------------------------------------------------------------------------
// flpte_pkg
// Shared widths, codes and helpers of the four-level page table engine.
// ----------------------------------------------------------------------------
package flpte_pkg;

	localparam int TABLE_PAGES_DEF = 64;

	localparam int ENTRY_W  = 64;
	localparam int IDX_W    = 9;
	localparam int VA_W     = 48;
	localparam int PA_W     = 52;
	localparam int FLAG_W   = 12;
	localparam int OFS_W    = 12;
	localparam int FRAME_W  = ENTRY_W - OFS_W;
	localparam int STATUS_W = 3;
	localparam int VPN_W    = VA_W - OFS_W;
	localparam int ENTRIES  = 512;

	localparam logic [1:0] MODE_TRANSLATE = 2'd0;
	localparam logic [1:0] MODE_MAP       = 2'd1;
	localparam logic [1:0] MODE_UNMAP     = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
	localparam logic [STATUS_W-1:0] ST_NULL       = 3'd1;
	localparam logic [STATUS_W-1:0] ST_UNALIGNED  = 3'd2;
	localparam logic [STATUS_W-1:0] ST_NOT_MAPPED = 3'd3;
	localparam logic [STATUS_W-1:0] ST_EXISTS     = 3'd4;
	localparam logic [STATUS_W-1:0] ST_OOM        = 3'd5;

	localparam logic [1:0] LVL_LEAF = 2'd3;

	typedef enum logic [4:0] {
		S_CLEAR = 5'b00001,
		S_IDLE  = 5'b00010,
		S_READ  = 5'b00100,
		S_EVAL  = 5'b01000,
		S_DONE  = 5'b10000
	} state_t;

	// Level 0 is the root (bits 47:39), level 3 the leaf table (bits 20:12).
	function automatic logic [IDX_W-1:0] level_index(logic [VA_W-1:0] va, logic [1:0] lvl);
		logic [IDX_W-1:0] idx;
		case (lvl)
			2'd0:    idx = va[47:39];
			2'd1:    idx = va[38:30];
			2'd2:    idx = va[29:21];
			default: idx = va[20:12];
		endcase
		return idx;
	endfunction

endpackage

FILE: design/flpte_req_if.sv
// ----------------------------------------------------------------------------
// flpte_req_if
// Request channel: valid/ready handshake carrying one request word.
// ----------------------------------------------------------------------------
interface flpte_req_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    mode;
	logic [flpte_pkg::VA_W-1:0]    virt_addr;
	logic [flpte_pkg::PA_W-1:0]    phys_addr;
	logic [flpte_pkg::FLAG_W-1:0]  table_flags;
	logic [flpte_pkg::FLAG_W-1:0]  page_flags;
	logic                          can_override;

	modport source (
		output valid, mode, virt_addr, phys_addr, table_flags, page_flags, can_override,
		input  ready
	);
	modport sink (
		input  valid, mode, virt_addr, phys_addr, table_flags, page_flags, can_override,
		output ready
	);
endinterface

FILE: design/flpte_rsp_if.sv
// ----------------------------------------------------------------------------
// flpte_rsp_if
// Response channel: valid/ready handshake carrying one result word.
// ----------------------------------------------------------------------------
interface flpte_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [flpte_pkg::STATUS_W-1:0] status;
	logic [flpte_pkg::ENTRY_W-1:0]  phys_result;
	logic                           invalidate;
	logic [flpte_pkg::VPN_W-1:0]    invalidate_page;

	modport source (
		output valid, status, phys_result, invalidate, invalidate_page,
		input  ready
	);
	modport sink (
		input  valid, status, phys_result, invalidate, invalidate_page,
		output ready
	);
endinterface

FILE: design/flpte_ram.sv
// ----------------------------------------------------------------------------
// flpte_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module flpte_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 32768,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: design/four_level_page_table_engine_unit.sv
// ----------------------------------------------------------------------------
// four_level_page_table_engine_unit
// Four-level radix page table kept in a local table store, with translate,
// map and unmap requests and a bump allocator for new table pages.
// ----------------------------------------------------------------------------
// After reset the block sweeps the TABLE_PAGES*512 entries of the table store
// (32768 at the default size) to zero, one entry a cycle; req.ready stays low
// until the sweep is done, while pool_base writes are taken at any time. A
// request that walks the table is taken into the request registers, then gets
// a read and an evaluate state per level on the single read port of the store,
// then is loaded into the output register once that is free. A walk that stops
// early skips the states of the levels below; a request that fails its argument
// checks goes straight to the done state. One request is in flight at a time;
// a finished result waits in the output register while the next one is taken.
module four_level_page_table_engine_unit #(
	parameter int TABLE_PAGES = flpte_pkg::TABLE_PAGES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [flpte_pkg::PA_W-1:0] cfg_wr_data,
	flpte_req_if.sink                  req,
	flpte_rsp_if.source                rsp
);

	localparam int PW    = $clog2(TABLE_PAGES);
	localparam int DEPTH = TABLE_PAGES * flpte_pkg::ENTRIES;
	localparam int AW    = PW + flpte_pkg::IDX_W;
	localparam int CW    = $clog2(TABLE_PAGES + 1);
	localparam int BW    = flpte_pkg::PA_W - flpte_pkg::OFS_W;

	flpte_pkg::state_t state_q;

	logic [BW-1:0]                      pool_frame_q;
	logic [CW-1:0]                      pages_used_q;
	logic [AW-1:0]                      clr_addr_q;

	logic [1:0]                         mode_q;
	logic [flpte_pkg::VA_W-1:0]         va_q;
	logic [flpte_pkg::PA_W-1:0]         pa_q;
	logic [flpte_pkg::FLAG_W-1:0]       tflags_q;
	logic [flpte_pkg::FLAG_W-1:0]       pflags_q;
	logic                               over_q;
	logic [1:0]                         lvl_q;
	logic [PW-1:0]                      page_q;

	logic [flpte_pkg::STATUS_W-1:0]     status_q;
	logic [flpte_pkg::ENTRY_W-1:0]      result_q;
	logic                               inval_q;

	logic                               rsp_valid_q;
	logic [flpte_pkg::STATUS_W-1:0]     rsp_status_q;
	logic [flpte_pkg::ENTRY_W-1:0]      rsp_result_q;
	logic                               rsp_inval_q;
	logic [flpte_pkg::VPN_W-1:0]        rsp_vpn_q;

	logic [AW-1:0]                      rd_addr;
	logic [flpte_pkg::ENTRY_W-1:0]      rd_data;
	logic                               ram_we;
	logic [AW-1:0]                      ram_waddr;
	logic [flpte_pkg::ENTRY_W-1:0]      ram_wdata;

	logic                               eval_we;
	logic [flpte_pkg::ENTRY_W-1:0]      eval_wdata;
	logic                               entry_zero;
	logic                               can_alloc;
	logic [flpte_pkg::FRAME_W-1:0]      alloc_frame;
	logic [flpte_pkg::ENTRY_W-1:0]      new_entry;
	logic [flpte_pkg::ENTRY_W-1:0]      eff_entry;
	logic [flpte_pkg::FRAME_W-1:0]      pool_off;
	logic                               in_pool;
	logic                               req_fire;
	logic                               out_load;
	logic                               is_leaf;

	assign req.ready = (state_q == flpte_pkg::S_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign out_load  = (state_q == flpte_pkg::S_DONE) && (!rsp_valid_q || rsp.ready);

	assign rd_addr    = {page_q, flpte_pkg::level_index(va_q, lvl_q)};
	assign is_leaf    = (lvl_q == flpte_pkg::LVL_LEAF);
	assign entry_zero = (rd_data == '0);
	assign can_alloc  = (pages_used_q < CW'(TABLE_PAGES));

	// New table page address: pool frame plus pages taken so far.
	assign alloc_frame = flpte_pkg::FRAME_W'(pool_frame_q) + flpte_pkg::FRAME_W'(pages_used_q);
	assign new_entry   = {alloc_frame, tflags_q};
	assign eff_entry   = entry_zero ? new_entry : rd_data;

	// Page number of the entry relative to the pool, modulo the frame width.
	assign pool_off = eff_entry[flpte_pkg::ENTRY_W-1:flpte_pkg::OFS_W]
	                  - flpte_pkg::FRAME_W'(pool_frame_q);
	assign in_pool  = (pool_off < flpte_pkg::FRAME_W'(TABLE_PAGES));

	always_comb begin
		eval_we    = 1'b0;
		eval_wdata = '0;
		if (state_q == flpte_pkg::S_EVAL) begin
			if (is_leaf) begin
				if (mode_q == flpte_pkg::MODE_MAP && (entry_zero || over_q)) begin
					eval_we    = 1'b1;
					eval_wdata = {{(flpte_pkg::ENTRY_W-flpte_pkg::PA_W){1'b0}}, pa_q}
					             | {{(flpte_pkg::ENTRY_W-flpte_pkg::FLAG_W){1'b0}}, pflags_q};
				end else if (mode_q == flpte_pkg::MODE_UNMAP &&
				             rd_data[flpte_pkg::ENTRY_W-1:flpte_pkg::OFS_W] != '0) begin
					eval_we    = 1'b1;
					eval_wdata = '0;
				end
			end else if (entry_zero && mode_q == flpte_pkg::MODE_MAP && can_alloc) begin
				eval_we    = 1'b1;
				eval_wdata = new_entry;
			end
		end
	end

	// The sweep owns the write port until the store is clear.
	assign ram_we    = (state_q == flpte_pkg::S_CLEAR) || eval_we;
	assign ram_waddr = (state_q == flpte_pkg::S_CLEAR) ? clr_addr_q : rd_addr;
	assign ram_wdata = (state_q == flpte_pkg::S_CLEAR) ? '0 : eval_wdata;

	flpte_ram #(
		.WIDTH (flpte_pkg::ENTRY_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_frame_q <= '0;
		end else if (cfg_wr_en) begin
			pool_frame_q <= cfg_wr_data[flpte_pkg::PA_W-1:flpte_pkg::OFS_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= flpte_pkg::S_CLEAR;
			clr_addr_q   <= '0;
			pages_used_q <= CW'(1);
			lvl_q        <= '0;
			page_q       <= '0;
		end else begin
			case (state_q)
				flpte_pkg::S_CLEAR: begin
					clr_addr_q <= clr_addr_q + AW'(1);
					if (clr_addr_q == AW'(DEPTH - 1)) begin
						state_q <= flpte_pkg::S_IDLE;
					end
				end
				flpte_pkg::S_IDLE: begin
					if (req_fire) begin
						lvl_q  <= '0;
						page_q <= '0;
						case (req.mode)
							flpte_pkg::MODE_TRANSLATE: begin
								state_q <= flpte_pkg::S_READ;
							end
							flpte_pkg::MODE_MAP: begin
								if ((req.virt_addr == '0 && req.phys_addr == '0) ||
								    req.virt_addr[flpte_pkg::OFS_W-1:0] != '0 ||
								    req.phys_addr[flpte_pkg::OFS_W-1:0] != '0) begin
									state_q <= flpte_pkg::S_DONE;
								end else begin
									state_q <= flpte_pkg::S_READ;
								end
							end
							flpte_pkg::MODE_UNMAP: begin
								if (req.virt_addr[flpte_pkg::VA_W-1:flpte_pkg::OFS_W] == '0 ||
								    req.virt_addr[flpte_pkg::OFS_W-1:0] != '0) begin
									state_q <= flpte_pkg::S_DONE;
								end else begin
									state_q <= flpte_pkg::S_READ;
								end
							end
							default: begin
								state_q <= flpte_pkg::S_DONE;
							end
						endcase
					end
				end
				flpte_pkg::S_READ: begin
					state_q <= flpte_pkg::S_EVAL;
				end
				flpte_pkg::S_EVAL: begin
					if (is_leaf) begin
						state_q <= flpte_pkg::S_DONE;
					end else if (entry_zero && mode_q != flpte_pkg::MODE_MAP) begin
						state_q <= flpte_pkg::S_DONE;
					end else if (entry_zero && !can_alloc) begin
						state_q <= flpte_pkg::S_DONE;
					end else begin
						if (entry_zero) begin
							pages_used_q <= pages_used_q + CW'(1);
						end
						if (in_pool) begin
							page_q  <= pool_off[PW-1:0];
							lvl_q   <= lvl_q + 2'd1;
							state_q <= flpte_pkg::S_READ;
						end else begin
							state_q <= flpte_pkg::S_DONE;
						end
					end
				end
				flpte_pkg::S_DONE: begin
					if (out_load) begin
						state_q <= flpte_pkg::S_IDLE;
					end
				end
				default: begin
					state_q <= flpte_pkg::S_IDLE;
				end
			endcase
		end
	end

	// Request word and running outcome.
	always_ff @(posedge clk) begin
		if (req_fire) begin
			mode_q   <= req.mode;
			va_q     <= req.virt_addr;
			pa_q     <= req.phys_addr;
			tflags_q <= req.table_flags;
			pflags_q <= req.page_flags;
			over_q   <= req.can_override;
			result_q <= '0;
			inval_q  <= 1'b0;
			case (req.mode)
				flpte_pkg::MODE_TRANSLATE: begin
					status_q <= flpte_pkg::ST_OK;
				end
				flpte_pkg::MODE_MAP: begin
					if (req.virt_addr == '0 && req.phys_addr == '0) begin
						status_q <= flpte_pkg::ST_NULL;
					end else if (req.virt_addr[flpte_pkg::OFS_W-1:0] != '0 ||
					             req.phys_addr[flpte_pkg::OFS_W-1:0] != '0) begin
						status_q <= flpte_pkg::ST_UNALIGNED;
					end else begin
						status_q <= flpte_pkg::ST_OK;
					end
				end
				flpte_pkg::MODE_UNMAP: begin
					if (req.virt_addr == '0) begin
						status_q <= flpte_pkg::ST_NULL;
					end else if (req.virt_addr[flpte_pkg::OFS_W-1:0] != '0) begin
						status_q <= flpte_pkg::ST_UNALIGNED;
					end else begin
						status_q <= flpte_pkg::ST_OK;
					end
				end
				default: begin
					status_q <= flpte_pkg::ST_NULL;
				end
			endcase
		end else if (state_q == flpte_pkg::S_EVAL) begin
			if (is_leaf) begin
				case (mode_q)
					flpte_pkg::MODE_TRANSLATE: begin
						if (entry_zero) begin
							status_q <= flpte_pkg::ST_NOT_MAPPED;
						end else begin
							result_q <= {rd_data[flpte_pkg::ENTRY_W-1:flpte_pkg::OFS_W],
							             va_q[flpte_pkg::OFS_W-1:0]};
						end
					end
					flpte_pkg::MODE_MAP: begin
						if (entry_zero || over_q) begin
							inval_q <= 1'b1;
						end else begin
							status_q <= flpte_pkg::ST_EXISTS;
						end
					end
					default: begin
						if (rd_data[flpte_pkg::ENTRY_W-1:flpte_pkg::OFS_W] == '0) begin
							status_q <= flpte_pkg::ST_NOT_MAPPED;
						end else begin
							inval_q <= 1'b1;
						end
					end
				endcase
			end else if (entry_zero && mode_q != flpte_pkg::MODE_MAP) begin
				status_q <= flpte_pkg::ST_NOT_MAPPED;
			end else if (entry_zero && !can_alloc) begin
				status_q <= flpte_pkg::ST_OOM;
			end else if (!in_pool) begin
				status_q <= flpte_pkg::ST_NOT_MAPPED;
			end
		end
	end

	// Output register: hold the word until the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			rsp_status_q <= status_q;
			rsp_result_q <= result_q;
			rsp_inval_q  <= inval_q;
			rsp_vpn_q    <= inval_q ? va_q[flpte_pkg::VA_W-1:flpte_pkg::OFS_W] : '0;
		end
	end

	assign rsp.valid           = rsp_valid_q;
	assign rsp.status          = rsp_status_q;
	assign rsp.phys_result     = rsp_result_q;
	assign rsp.invalidate      = rsp_inval_q;
	assign rsp.invalidate_page = rsp_vpn_q;

endmodule

FILE: design/flpte_checker.sv
// ----------------------------------------------------------------------------
// flpte_checker
// Port-level checks on the page table engine's result channel.
// ----------------------------------------------------------------------------
module flpte_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           rsp_valid,
	input logic                           rsp_ready,
	input logic [flpte_pkg::STATUS_W-1:0] status,
	input logic [flpte_pkg::ENTRY_W-1:0]  phys_result,
	input logic                           invalidate,
	input logic [flpte_pkg::VPN_W-1:0]    invalidate_page
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result word dropped before it was taken");

	a_inval_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && invalidate |-> status == flpte_pkg::ST_OK)
		else $error("invalidate raised on a failed request");

	a_result_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && phys_result != '0 |-> status == flpte_pkg::ST_OK && !invalidate)
		else $error("translation returned on a failed or modifying request");

	a_vpn_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !invalidate |-> invalidate_page == '0)
		else $error("invalidate page set without invalidate");

endmodule

bind four_level_page_table_engine_unit flpte_checker u_flpte_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.status          (rsp.status),
	.phys_result     (rsp.phys_result),
	.invalidate      (rsp.invalidate),
	.invalidate_page (rsp.invalidate_page)
);

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives translate, map and unmap words into the page table engine and checks
// each result word against a shadow of the table store and the bump allocator,
// or a pinned row's against its fixed outcome. A short table of hand-picked words
// runs first, then random traffic under several pool bases and idling patterns.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import flpte_pkg::*;

	localparam int          N_PAGES      = TABLE_PAGES_DEF;
	localparam logic [63:0] FRAME_MASK   = 64'hFFFF_FFFF_FFFF_F000;
	localparam logic [63:0] PAGE_STEP    = 64'h1000;
	localparam logic [1:0]  MODE_BAD     = 2'd3;
	localparam int          DRAIN_CYCLES = 40;

	typedef struct packed {
		logic [1:0]        mode;
		logic [VA_W-1:0]   va;
		logic [PA_W-1:0]   pa;
		logic [FLAG_W-1:0] tflags;
		logic [FLAG_W-1:0] pflags;
		logic              over;
	} walk_req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [ENTRY_W-1:0]  phys;
		logic                inval;
		logic [VPN_W-1:0]    page;
	} walk_rsp_t;

	typedef struct packed {
		walk_req_t           req;
		logic                pinned;
		logic [STATUS_W-1:0] status;
	} step_row_t;

	// Pinned rows carry a fixed status, checked in place of the shadow's result.
	localparam int PLAN_LEN = 26;
	localparam step_row_t PLAN [PLAN_LEN] = '{
		'{'{MODE_TRANSLATE, 48'h0000_0000_0000, 52'h0, 12'h000, 12'h000, 1'b0}, 1'b1, ST_NOT_MAPPED},
		'{'{MODE_TRANSLATE, 48'hFFFF_FFFF_FFFF, 52'h0, 12'hFFF, 12'hFFF, 1'b1}, 1'b1, ST_NOT_MAPPED},
		'{'{MODE_MAP, 48'h0000_0000_0000, 52'h0, 12'h003, 12'h003, 1'b0}, 1'b1, ST_NULL},
		'{'{MODE_UNMAP, 48'h0000_0000_0000, 52'hF_FFFF_FFFF_F000, 12'h0, 12'h0, 1'b0}, 1'b1, ST_NULL},
		'{'{MODE_BAD, 48'h0000_1000_0000, 52'h5000, 12'h000, 12'h000, 1'b0}, 1'b1, ST_NULL},
		'{'{MODE_MAP, 48'h0000_0000_1234, 52'h5000, 12'h001, 12'h001, 1'b0}, 1'b1, ST_UNALIGNED},
		'{'{MODE_MAP, 48'h0000_0000_7000, 52'h5001, 12'h001, 12'h001, 1'b0}, 1'b1, ST_UNALIGNED},
		'{'{MODE_MAP, 48'h0000_0000_0001, 52'h0, 12'h001, 12'h001, 1'b1}, 1'b1, ST_UNALIGNED},
		'{'{MODE_UNMAP, 48'h0000_0000_1001, 52'h0, 12'h000, 12'h000, 1'b0}, 1'b1, ST_UNALIGNED},
		'{'{MODE_UNMAP, 48'h0000_0000_1000, 52'h0, 12'h000, 12'h000, 1'b0}, 1'b1, ST_NOT_MAPPED},
		'{'{MODE_MAP, 48'h0000_0000_0000, 52'hF_FFFF_FFFF_F000, 12'hFFF, 12'hFFF, 1'b0}, 1'b0, ST_OK},
		'{'{MODE_TRANSLATE, 48'h0000_0000_0FFF, 52'h0, 12'h000, 12'h000, 1'b0}, 1'b0, ST_OK},
		'{'{MODE_MAP, 48'h0000_0000_0000, 52'h2000, 12'h001, 12'h001, 1'b0}, 1'b0, ST_OK},
		'{'{MODE_MAP, 48'h0000_0000_0000, 52'h2000, 12'h001, 12'h000, 1'b1}, 1'b0, ST_OK},
		'{'{MODE_TRANSLATE, 48'h0000_0000_0123, 52'h0, 12'h000, 12'h000, 1'b0}, 1'b0, ST_OK},
		'{'{MODE_MAP, 48'hFFFF_FFFF_F000, 52'hF_FFFF_FFFF_F000, 12'hFFF, 12'hFFF, 1'b0}, 1'b0, ST_OK},
		'{'{MODE_TRANSLATE, 48'hFFFF_FFFF_FFFF, 52'h0, 12'h000, 12'h000, 1'b0}, 1'b0, ST_OK},
		'{'{MODE_UNMAP, 48'hFFFF_FFFF_F000, 52'h0, 12'h000, 12'h000, 1'b0}, 1'b0, ST_OK},
		'{'{MODE_TRANSLATE, 48'hFFFF_FFFF_F800, 52'h0, 12'h000, 12'h000, 1'b0}, 1'b0, ST_OK},
		'{'{MODE_UNMAP, 48'hFFFF_FFFF_F000, 52'h0, 12'h000, 12'h000, 1'b0}, 1'b0, ST_OK},
		'{'{MODE_MAP, 48'h0000_4000_0000, 52'h0, 12'h007, 12'h0A5, 1'b0}, 1'b0, ST_OK},
		'{'{MODE_UNMAP, 48'h0000_4000_0000, 52'h0, 12'h000, 12'h000, 1'b0}, 1'b0, ST_OK},
		'{'{MODE_TRANSLATE, 48'h0000_4000_0ABC, 52'h0, 12'h000, 12'h000, 1'b0}, 1'b0, ST_OK},
		'{'{MODE_MAP, 48'h0080_0000_0000, 52'h1234_5000, 12'h000, 12'h000, 1'b0}, 1'b0, ST_OK},
		'{'{MODE_TRANSLATE, 48'h0080_0000_0ABC, 52'h0, 12'h000, 12'h000, 1'b0}, 1'b0, ST_OK},
		'{'{MODE_BAD, 48'hFFFF_FFFF_FFFF, 52'hF_FFFF_FFFF_FFFF, 12'hFFF, 12'hFFF, 1'b1}, 1'b1, ST_NULL}
	};

	logic            clk         = 1'b0;
	logic            arst_n      = 1'b0;
	logic            cfg_wr_en   = 1'b0;
	logic [PA_W-1:0] cfg_wr_data = '0;

	flpte_req_if req_ch ();
	flpte_rsp_if rsp_ch ();

	four_level_page_table_engine_unit #(
		.TABLE_PAGES(N_PAGES)
	) uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.req        (req_ch),
		.rsp        (rsp_ch)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Shadow of the table store, allocator and pool base.
	logic [ENTRY_W-1:0] shadow_tables [N_PAGES*ENTRIES];
	int unsigned        shadow_pages_used = 1;
	logic [PA_W-1:0]    shadow_pool_base  = '0;

	walk_rsp_t   owed_outcomes [$];
	int unsigned faults    = 0;
	int unsigned gap_pct   = 0;
	int unsigned stall_pct = 0;
	logic        row_pinned = 1'b0;
	walk_rsp_t   row_outcome = '0;
	logic [VA_W-1:0] regions [8];

	task automatic report_fault(string what, logic [63:0] want, logic [63:0] got);
		faults++;
		$display("%0t ns: %s mismatch: expected %h, got %h", $realtime, what, want, got);
	endtask

	// Walk down to the leaf table; fill holes from the allocator when grow is set.
	function automatic logic [STATUS_W-1:0] descend(logic [VA_W-1:0] va, logic grow,
			logic [FLAG_W-1:0] tflags, output int leaf_slot);
		int          page;
		int          slot;
		logic [63:0] e;
		logic [63:0] off;
		logic [63:0] base;
		base = {12'b0, shadow_pool_base} & FRAME_MASK;
		page = 0;
		leaf_slot = 0;
		for (int lvl = 0; lvl < 3; lvl++) begin
			slot = page * ENTRIES + int'((va >> (39 - 9 * lvl)) & 48'h1FF);
			e = shadow_tables[slot];
			if (e == '0) begin
				if (!grow)
					return ST_NOT_MAPPED;
				if (shadow_pages_used >= N_PAGES)
					return ST_OOM;
				e = (base + 64'(shadow_pages_used) * PAGE_STEP) | 64'(tflags);
				shadow_pages_used++;
				shadow_tables[slot] = e;
			end
			// an entry off the pool pages counts as absent
			off = ((e & FRAME_MASK) - base) >> 12;
			if (off >= 64'(N_PAGES))
				return ST_NOT_MAPPED;
			page = int'(off);
		end
		leaf_slot = page * ENTRIES + int'(va[20:12]);
		return ST_OK;
	endfunction

	function automatic walk_rsp_t resolve_request(walk_req_t r);
		walk_rsp_t   o;
		int          leaf;
		logic [63:0] e;
		o = '0;
		case (r.mode)
			MODE_TRANSLATE: begin
				o.status = descend(r.va, 1'b0, '0, leaf);
				if (o.status == ST_OK) begin
					e = shadow_tables[leaf];
					if (e == '0)
						o.status = ST_NOT_MAPPED;
					else
						o.phys = (e & FRAME_MASK) + 64'(r.va[OFS_W-1:0]);
				end
			end
			MODE_MAP: begin
				if (r.va == '0 && r.pa == '0) begin
					o.status = ST_NULL;
				end else if (r.va[OFS_W-1:0] != '0 || r.pa[OFS_W-1:0] != '0) begin
					o.status = ST_UNALIGNED;
				end else begin
					o.status = descend(r.va, 1'b1, r.tflags, leaf);
					if (o.status == ST_OK) begin
						if (shadow_tables[leaf] == '0 || r.over) begin
							shadow_tables[leaf] = 64'(r.pa) | 64'(r.pflags);
							o.inval = 1'b1;
						end else begin
							o.status = ST_EXISTS;
						end
					end
				end
			end
			MODE_UNMAP: begin
				if (r.va == '0) begin
					o.status = ST_NULL;
				end else if (r.va[OFS_W-1:0] != '0) begin
					o.status = ST_UNALIGNED;
				end else begin
					o.status = descend(r.va, 1'b0, '0, leaf);
					if (o.status == ST_OK) begin
						// a leaf holding only flags has nothing to drop
						if ((shadow_tables[leaf] & FRAME_MASK) == '0) begin
							o.status = ST_NOT_MAPPED;
						end else begin
							shadow_tables[leaf] = '0;
							o.inval = 1'b1;
						end
					end
				end
			end
			default: begin
				o.status = ST_NULL;
			end
		endcase
		if (o.inval)
			o.page = r.va[VA_W-1:OFS_W];
		return o;
	endfunction

	// Mostly well-formed words aimed at a few regions, so tables get reused.
	function automatic walk_req_t random_word();
		walk_req_t   w;
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 40)
			w.mode = MODE_MAP;
		else if (pick < 70)
			w.mode = MODE_TRANSLATE;
		else if (pick < 95)
			w.mode = MODE_UNMAP;
		else
			w.mode = MODE_BAD;
		pick = $urandom_range(99);
		if (pick < 85)
			w.va = regions[$urandom_range(7)] | (48'($urandom_range(7)) << 12);
		else if (pick < 90)
			w.va = 48'({$urandom, $urandom}) & ~48'hFFF;
		else if (pick < 96)
			w.va = 48'({$urandom, $urandom});
		else
			w.va = '0;
		if (w.mode == MODE_TRANSLATE && $urandom_range(1) == 1)
			w.va[OFS_W-1:0] = 12'($urandom);
		pick = $urandom_range(99);
		if (pick < 88)
			w.pa = 52'({$urandom, $urandom}) & ~52'hFFF;
		else if (pick < 94)
			w.pa = '0;
		else
			w.pa = 52'({$urandom, $urandom});
		w.tflags = 12'($urandom);
		w.pflags = 12'($urandom);
		w.over = ($urandom_range(99) < 30);
		return w;
	endfunction

	// Offer one word at a falling edge; return at the falling edge after it is taken.
	task automatic offer(walk_req_t w, logic pinned, logic [STATUS_W-1:0] pinned_status);
		while ($urandom_range(99) < gap_pct) begin
			req_ch.valid = 1'b0;
			@(negedge clk);
		end
		req_ch.valid        = 1'b1;
		req_ch.mode         = w.mode;
		req_ch.virt_addr    = w.va;
		req_ch.phys_addr    = w.pa;
		req_ch.table_flags  = w.tflags;
		req_ch.page_flags   = w.pflags;
		req_ch.can_override = w.over;
		row_pinned  = pinned;
		row_outcome = '{pinned_status, 64'h0, 1'b0, 36'h0};
		do
			@(posedge clk);
		while (!req_ch.ready);
		@(negedge clk);
	endtask

	// Hold the sender until every owed word is back, then let the block go quiet.
	task automatic settle();
		req_ch.valid = 1'b0;
		while (owed_outcomes.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic set_pool_base(logic [PA_W-1:0] value);
		cfg_wr_en   = 1'b1;
		cfg_wr_data = value;
		@(negedge clk);
		cfg_wr_en   = 1'b0;
	endtask

	task automatic run_phase(int unsigned gap, int unsigned stall, int count);
		gap_pct   = gap;
		stall_pct = stall;
		for (int k = 0; k < count; k++) begin
			if (k % 150 == 149) begin
				while (owed_outcomes.size() != 0) begin
					req_ch.valid = 1'b0;
					@(negedge clk);
				end
			end
			offer(random_word(), 1'b0, ST_OK);
		end
	endtask

	always @(negedge clk)
		rsp_ch.ready = ($urandom_range(99) >= stall_pct);

	always @(posedge clk) begin
		walk_rsp_t predicted;
		walk_rsp_t want;
		if (cfg_wr_en)
			shadow_pool_base = cfg_wr_data;
		if (arst_n && req_ch.valid && req_ch.ready) begin
			predicted = resolve_request('{req_ch.mode, req_ch.virt_addr, req_ch.phys_addr,
				req_ch.table_flags, req_ch.page_flags, req_ch.can_override});
			owed_outcomes.push_back(row_pinned ? row_outcome : predicted);
		end
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (owed_outcomes.size() == 0) begin
				report_fault("unowed word, status", 64'h0, 64'(rsp_ch.status));
			end else begin
				want = owed_outcomes.pop_front();
				if (rsp_ch.status !== want.status)
					report_fault("status", 64'(want.status), 64'(rsp_ch.status));
				if (rsp_ch.phys_result !== want.phys)
					report_fault("phys_result", want.phys, rsp_ch.phys_result);
				if (rsp_ch.invalidate !== want.inval)
					report_fault("invalidate", 64'(want.inval), 64'(rsp_ch.invalidate));
				if (rsp_ch.invalidate_page !== want.page)
					report_fault("invalidate_page", 64'(want.page), 64'(rsp_ch.invalidate_page));
			end
		end
	end

	initial begin
		logic [PA_W-1:0] main_base;
		req_ch.valid        = 1'b0;
		req_ch.mode         = MODE_TRANSLATE;
		req_ch.virt_addr    = '0;
		req_ch.phys_addr    = '0;
		req_ch.table_flags  = '0;
		req_ch.page_flags   = '0;
		req_ch.can_override = 1'b0;
		rsp_ch.ready        = 1'b0;
		foreach (shadow_tables[i])
			shadow_tables[i] = '0;
		// region tops stay clear of the root slots the table uses
		foreach (regions[i])
			regions[i] = {9'($urandom_range(510, 2)), 9'($urandom), 9'($urandom), 21'b0};
		main_base = 52'({$urandom, $urandom});

		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		set_pool_base('0);
		for (int i = 0; i < PLAN_LEN; i++)
			offer(PLAN[i].req, PLAN[i].pinned, PLAN[i].status);

		settle();
		set_pool_base(main_base);
		run_phase(0, 0, 450);
		run_phase(76, 0, 450);
		settle();
		set_pool_base(52'hF_FFFF_FFFF_FFFF);
		run_phase(13, 13, 120);
		settle();
		// same frame, other ignored low bits
		set_pool_base(main_base ^ 52'hFFF);
		run_phase(0, 76, 450);
		settle();
		set_pool_base('0);
		run_phase(0, 0, 60);
		settle();
		set_pool_base(main_base);
		run_phase(13, 13, 420);
		settle();

		if (faults == 0)
			$display("four_level_page_table_engine_unit test passed");
		else
			$display("four_level_page_table_engine_unit test failed");
		$finish;
	end

	initial begin
		#12ms;
		$display("four_level_page_table_engine_unit test failed");
		$finish;
	end

endmodule

FILE: sim.f
design/flpte_pkg.sv
design/flpte_req_if.sv
design/flpte_rsp_if.sv
design/flpte_ram.sv
design/four_level_page_table_engine_unit.sv
design/flpte_checker.sv
tb/testbench.sv
